>>> hw/rtl/cursor_array_list_engine_core_defines.svh
// assertion macros for the list engine rtl
`ifndef CURSOR_ARRAY_LIST_ENGINE_CORE_DEFINES_SVH
`define CURSOR_ARRAY_LIST_ENGINE_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define CALE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("list engine assertion failed");

// next-cycle implication, disabled while reset is asserted
`define CALE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("list engine assertion failed");

`endif

>>> hw/rtl/cale_pkg.sv
`default_nettype none

package cale_pkg;

	localparam int DEPTH_DEF      = 256;
	localparam int DATA_WIDTH_DEF = 32;

	// item field widths and tdata layout
	localparam int CMD_W       = 4;
	localparam int VALUE_W     = 32;
	localparam int POS_W       = 8;
	localparam int COUNT_W     = 9;
	localparam int CURSOR_W    = 8;
	localparam int CMD_LSB     = 0;
	localparam int VALUE_LSB   = CMD_LSB + CMD_W;
	localparam int POS_LSB     = VALUE_LSB + VALUE_W;
	localparam int IN_TDATA_W  = 48;
	localparam int MOVED_LSB   = VALUE_W;
	localparam int STATUS_LSB  = MOVED_LSB + 1;
	localparam int COUNT_LSB   = STATUS_LSB + 2;
	localparam int CURSOR_LSB  = COUNT_LSB + COUNT_W;
	localparam int OUT_USED_W  = CURSOR_LSB + CURSOR_W;
	localparam int OUT_TDATA_W = 56;
	localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_USED_W;

	typedef enum logic [3:0] {
		CMD_READ_CUR   = 4'd0,
		CMD_WRITE_CUR  = 4'd1,
		CMD_PREV       = 4'd2,
		CMD_NEXT       = 4'd3,
		CMD_FIRST      = 4'd4,
		CMD_LAST       = 4'd5,
		CMD_DELETE     = 4'd6,
		CMD_INS_BEFORE = 4'd7,
		CMD_INS_AFTER  = 4'd8,
		CMD_READ_POS   = 4'd9,
		CMD_WRITE_POS  = 4'd10
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_BAD_INDEX = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_RDWAIT,
		S_SHIFT,
		S_DRAIN,
		S_FINAL,
		S_DONE
	} state_t;

	typedef enum logic [1:0] {
		RA_CURSOR,
		RA_POS,
		RA_PTR
	} raddr_sel_t;

	typedef enum logic [2:0] {
		WA_NONE,
		WA_CURSOR,
		WA_CURSOR1,
		WA_POS,
		WA_ZERO
	} waddr_sel_t;

	typedef enum logic [3:0] {
		UPD_NONE,
		UPD_PREV,
		UPD_NEXT,
		UPD_FIRST,
		UPD_LAST,
		UPD_DEL,
		UPD_INS_BEFORE,
		UPD_INS_AFTER,
		UPD_INS_EMPTY
	} upd_t;

	// controller to datapath
	typedef struct packed {
		logic       load;
		logic       res_set;
		status_t    res_status;
		logic       res_moved;
		logic       res_rd;
		logic       mem_re;
		raddr_sel_t ra_sel;
		waddr_sel_t wa_sel;
		logic       shift_start;
		logic       shift_read;
		upd_t       upd;
		logic       out_load;
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		cmd_t cmd;
		logic empty;
		logic full;
		logic pos_bad;
		logic cur_first;
		logic cur_last;
		logic shift_end;
		logic shift_wr_pend;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

>>> hw/rtl/cursor_array_list_engine_core.sv
// cursor array list engine: an ordered list in a single element memory,
// with an element count and a cursor
// s_axis carries one command per beat, m_axis returns exactly one result beat
// per command, in order
// delete and insert shift up to DEPTH - 1 elements; the element memory has
// one write port, so the shift moves one element per cycle; one command is
// in work at a time and the next input beat is taken the cycle after the
// previous result is loaded into the output register
// reset clears the count, the cursor and m_axis_tvalid and idles the
// sequencer; the element memory is not cleared, holds nothing until written
// when m_axis_tready is low the finished result waits in the output register,
// the engine takes and works on one more command, then holds it until the
// output register frees up
`default_nettype none
`include "cursor_array_list_engine_core_defines.svh"

module cursor_array_list_engine_core import cale_pkg::*; #(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// command[3:0], value[35:4], position[43:36], zero pad
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// read_value[31:0], moved[32], status[34:33], element_count[43:35],
	// cursor_position[51:44], zero pad
	output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	ctl_t ctl;
	sts_t sts;

	// sequencer: decode, element shifting, result hand-off
	cale_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.ctl      (ctl)
	);

	// element memory, count and cursor, shift pointers, output register
	cale_datapath #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.sts       (sts),
		.in_data   (s_axis_tdata),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

	// one command in work at a time
	`CALE_ASSERT_NEXT(a_one_in_flight, clk, arst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

	// a shift write-back never meets a direct write on the single port
	`CALE_ASSERT_IMPL(a_no_wr_clash, clk, arst_n, sts.shift_wr_pend, ctl.wa_sel == WA_NONE)

	// reported count never exceeds the capacity
	`CALE_ASSERT_IMPL(a_count_cap, clk, arst_n, m_axis_tvalid, 32'(m_axis_tdata[COUNT_LSB +: COUNT_W]) <= DEPTH)

endmodule

`default_nettype wire

>>> hw/rtl/cale_ctrl.sv
`default_nettype none

module cale_ctrl import cale_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output ctl_t ctl
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		in_ready       = 1'b0;
		ctl            = '0;
		ctl.res_status = ST_OK;
		ctl.ra_sel     = RA_CURSOR;
		ctl.wa_sel     = WA_NONE;
		ctl.upd        = UPD_NONE;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				ctl.res_set = 1'b1;
				state_d     = S_DONE;
				if (sts.cmd inside {[CMD_READ_CUR:CMD_DELETE]} && sts.empty) begin
					ctl.res_status = ST_EMPTY;
				end else begin
					case (sts.cmd)
						CMD_READ_CUR: begin
							ctl.mem_re = 1'b1;
							ctl.ra_sel = RA_CURSOR;
							ctl.res_rd = 1'b1;
							state_d    = S_RDWAIT;
						end
						CMD_WRITE_CUR: begin
							ctl.wa_sel = WA_CURSOR;
						end
						CMD_PREV: begin
							ctl.upd       = UPD_PREV;
							ctl.res_moved = !sts.cur_first;
						end
						CMD_NEXT: begin
							ctl.upd       = UPD_NEXT;
							ctl.res_moved = !sts.cur_last;
						end
						CMD_FIRST: begin
							ctl.upd = UPD_FIRST;
						end
						CMD_LAST: begin
							ctl.upd = UPD_LAST;
						end
						CMD_DELETE: begin
							if (sts.cur_last) begin
								ctl.upd = UPD_DEL;
							end else begin
								ctl.shift_start = 1'b1;
								state_d         = S_SHIFT;
							end
						end
						CMD_INS_BEFORE, CMD_INS_AFTER: begin
							if (sts.full) begin
								ctl.res_status = ST_FULL;
							end else if (sts.empty) begin
								ctl.wa_sel = WA_ZERO;
								ctl.upd    = UPD_INS_EMPTY;
							end else if (sts.cmd == CMD_INS_AFTER && sts.cur_last) begin
								state_d = S_FINAL;
							end else begin
								ctl.shift_start = 1'b1;
								state_d         = S_SHIFT;
							end
						end
						CMD_READ_POS: begin
							if (sts.pos_bad) begin
								ctl.res_status = ST_BAD_INDEX;
							end else begin
								ctl.mem_re = 1'b1;
								ctl.ra_sel = RA_POS;
								ctl.res_rd = 1'b1;
								state_d    = S_RDWAIT;
							end
						end
						CMD_WRITE_POS: begin
							if (sts.pos_bad) begin
								ctl.res_status = ST_BAD_INDEX;
							end else begin
								ctl.wa_sel = WA_POS;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_RDWAIT: begin
				state_d = S_DONE;
			end
			S_SHIFT: begin
				ctl.mem_re     = 1'b1;
				ctl.ra_sel     = RA_PTR;
				ctl.shift_read = 1'b1;
				if (sts.shift_end) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				// last moved element is written back here
				if (sts.cmd == CMD_DELETE) begin
					ctl.upd = UPD_DEL;
					state_d = S_DONE;
				end else begin
					state_d = S_FINAL;
				end
			end
			S_FINAL: begin
				if (sts.cmd == CMD_INS_BEFORE) begin
					ctl.wa_sel = WA_CURSOR;
					ctl.upd    = UPD_INS_BEFORE;
				end else begin
					ctl.wa_sel = WA_CURSOR1;
					ctl.upd    = UPD_INS_AFTER;
				end
				state_d = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) begin
					ctl.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> hw/rtl/cale_datapath.sv
`default_nettype none

module cale_datapath import cale_pkg::*; #(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ctl_t                   ctl,
	output sts_t                   sts,
	input  logic [IN_TDATA_W-1:0]  in_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [OUT_TDATA_W-1:0] out_data
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [DATA_WIDTH-1:0] mem [DEPTH];

	cmd_t                  cmd_q;
	logic [DATA_WIDTH-1:0] value_q;
	logic [POS_W-1:0]      pos_q;
	logic [CW-1:0]         count_q;
	logic [AW-1:0]         cursor_q;
	logic [DATA_WIDTH-1:0] rdata_q;
	logic [AW-1:0]         rd_ptr_q;
	logic [AW-1:0]         end_q;
	logic                  shift_left_q;
	logic [AW-1:0]         wr_ptr_s1;
	logic                  wr_pend_s1;
	status_t               res_status_q;
	logic                  res_moved_q;
	logic                  res_rd_q;
	logic                  out_valid_q;
	logic [OUT_TDATA_W-1:0] out_data_q;

	logic [63:0]           value_ext;
	logic [CW-1:0]         count_dec;
	logic [AW-1:0]         count_m1;
	logic [AW-1:0]         cursor_inc;
	logic [31:0]           pos_ext;
	logic [AW-1:0]         pos_idx;
	logic [AW-1:0]         raddr;
	logic [AW-1:0]         waddr;
	logic [DATA_WIDTH-1:0] wdata;
	logic                  mem_we;
	logic [63:0]           rd_ext;
	logic [31:0]           rd_val;
	logic [31:0]           cnt_ext;
	logic [31:0]           cur_ext;

	assign value_ext  = {{32{in_data[VALUE_LSB+VALUE_W-1]}}, in_data[VALUE_LSB +: VALUE_W]};
	assign count_dec  = count_q - CW'(1);
	assign count_m1   = count_dec[AW-1:0];
	assign cursor_inc = cursor_q + AW'(1);
	assign pos_ext    = 32'(pos_q);
	assign pos_idx    = pos_ext[AW-1:0];

	always_comb begin
		sts               = '0;
		sts.cmd           = cmd_q;
		sts.empty         = (count_q == '0);
		sts.full          = (32'(count_q) >= DEPTH);
		sts.pos_bad       = (pos_ext >= 32'(count_q));
		sts.cur_first     = (cursor_q == '0);
		sts.cur_last      = ((32'(cursor_q) + 32'd1) >= 32'(count_q));
		sts.shift_end     = (rd_ptr_q == end_q);
		sts.shift_wr_pend = wr_pend_s1;
		sts.out_free      = !out_valid_q || out_ready;
	end

	always_comb begin
		case (ctl.ra_sel)
			RA_CURSOR: raddr = cursor_q;
			RA_POS:    raddr = pos_idx;
			RA_PTR:    raddr = rd_ptr_q;
			default:   raddr = cursor_q;
		endcase
	end

	// a pending shift write owns the port
	always_comb begin
		mem_we = 1'b0;
		waddr  = '0;
		wdata  = value_q;
		if (wr_pend_s1) begin
			mem_we = 1'b1;
			waddr  = wr_ptr_s1;
			wdata  = rdata_q;
		end else begin
			case (ctl.wa_sel)
				WA_CURSOR: begin
					mem_we = 1'b1;
					waddr  = cursor_q;
				end
				WA_CURSOR1: begin
					mem_we = 1'b1;
					waddr  = cursor_inc;
				end
				WA_POS: begin
					mem_we = 1'b1;
					waddr  = pos_idx;
				end
				WA_ZERO: begin
					mem_we = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= wdata;
		end
		if (ctl.mem_re) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			cursor_q    <= '0;
			wr_pend_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			wr_pend_s1 <= ctl.shift_read;
			case (ctl.upd)
				UPD_PREV: begin
					if (!sts.cur_first) begin
						cursor_q <= cursor_q - AW'(1);
					end
				end
				UPD_NEXT: begin
					if (!sts.cur_last) begin
						cursor_q <= cursor_inc;
					end
				end
				UPD_FIRST: cursor_q <= '0;
				UPD_LAST:  cursor_q <= count_m1;
				UPD_DEL: begin
					count_q <= count_dec;
					if (sts.cur_last && !sts.cur_first) begin
						cursor_q <= cursor_q - AW'(1);
					end
				end
				UPD_INS_BEFORE: begin
					cursor_q <= cursor_inc;
					count_q  <= count_q + CW'(1);
				end
				UPD_INS_AFTER: begin
					count_q <= count_q + CW'(1);
				end
				UPD_INS_EMPTY: begin
					cursor_q <= '0;
					count_q  <= CW'(1);
				end
				default: begin
				end
			endcase
			if (ctl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rd_ext  = 64'(rdata_q);
	assign rd_val  = res_rd_q ? rd_ext[31:0] : 32'd0;
	assign cnt_ext = 32'(count_q);
	assign cur_ext = 32'(cursor_q);

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q   <= cmd_t'(in_data[CMD_LSB +: CMD_W]);
			value_q <= value_ext[DATA_WIDTH-1:0];
			pos_q   <= in_data[POS_LSB +: POS_W];
		end
		if (ctl.shift_start) begin
			if (cmd_q == CMD_DELETE) begin
				shift_left_q <= 1'b1;
				rd_ptr_q     <= cursor_inc;
				end_q        <= count_m1;
			end else begin
				shift_left_q <= 1'b0;
				rd_ptr_q     <= count_m1;
				end_q        <= (cmd_q == CMD_INS_AFTER) ? cursor_inc : cursor_q;
			end
		end
		if (ctl.shift_read) begin
			if (shift_left_q) begin
				rd_ptr_q  <= rd_ptr_q + AW'(1);
				wr_ptr_s1 <= rd_ptr_q - AW'(1);
			end else begin
				rd_ptr_q  <= rd_ptr_q - AW'(1);
				wr_ptr_s1 <= rd_ptr_q + AW'(1);
			end
		end
		if (ctl.res_set) begin
			res_status_q <= ctl.res_status;
			res_moved_q  <= ctl.res_moved;
			res_rd_q     <= ctl.res_rd;
		end
		if (ctl.out_load) begin
			out_data_q <= {{OUT_PAD_W{1'b0}}, cur_ext[CURSOR_W-1:0], cnt_ext[COUNT_W-1:0],
				res_status_q, res_moved_q, rd_val};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

`default_nettype wire

>>> test/tb.sv
`timescale 1ns / 100ps

module tb import cale_pkg::*; ();

	// one expected result beat, fields as they sit in m_axis_tdata
	typedef struct packed {
		logic [VALUE_W-1:0]  read_value;
		logic                moved;
		status_t             status;
		logic [COUNT_W-1:0]  element_count;
		logic [CURSOR_W-1:0] cursor_position;
	} list_result_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	// command[3:0], value[35:4], position[43:36], zero pad
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	// read_value[31:0], moved[32], status[34:33], element_count[43:35],
	// cursor_position[51:44], zero pad
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	// shadow copy of the list, updated as each command beat is taken
	logic [VALUE_W-1:0] lst_mem [DEPTH_DEF];
	int                 lst_count = 0;
	int                 lst_cursor = 0;
	int                 lst_peak = 0;

	list_result_t pending_results [$];
	int           err_cnt = 0;
	int           cmds_sent = 0;
	int           results_seen = 0;
	int           src_idle_pct = 0;
	int           snk_idle_pct = 0;

	cursor_array_list_engine_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// generous ceiling, far beyond the slowest legal run
	initial begin
		#40000000;
		$display("** cursor_array_list_engine_core: FAILED **");
		$finish;
	end

	// apply one command to the shadow list and return the result it should give
	function automatic list_result_t next_list_result(input logic [CMD_W-1:0] op,
			input logic [VALUE_W-1:0] val, input logic [POS_W-1:0] idx);
		list_result_t r;
		int i;
		r = '0;
		r.status = ST_OK;
		if (op <= CMD_DELETE && lst_count == 0) begin
			r.status = ST_EMPTY;
		end else begin
			case (op)
				CMD_READ_CUR: r.read_value = lst_mem[lst_cursor];
				CMD_WRITE_CUR: lst_mem[lst_cursor] = val;
				CMD_PREV: begin
					if (lst_cursor > 0) begin
						lst_cursor--;
						r.moved = 1'b1;
					end
				end
				CMD_NEXT: begin
					if (lst_cursor + 1 < lst_count) begin
						lst_cursor++;
						r.moved = 1'b1;
					end
				end
				CMD_FIRST: lst_cursor = 0;
				CMD_LAST: lst_cursor = lst_count - 1;
				CMD_DELETE: begin
					// deleting the tail steps the cursor back, otherwise close the gap
					if (lst_cursor + 1 >= lst_count) begin
						if (lst_cursor > 0)
							lst_cursor--;
					end else begin
						for (i = lst_cursor; i + 1 < lst_count; i++)
							lst_mem[i] = lst_mem[i + 1];
					end
					lst_count--;
				end
				CMD_INS_BEFORE, CMD_INS_AFTER: begin
					if (lst_count >= DEPTH_DEF) begin
						r.status = ST_FULL;
					end else if (lst_count == 0) begin
						lst_mem[0] = val;
						lst_cursor = 0;
						lst_count = 1;
					end else if (op == CMD_INS_BEFORE) begin
						for (i = lst_count; i > lst_cursor; i--)
							lst_mem[i] = lst_mem[i - 1];
						lst_mem[lst_cursor] = val;
						lst_cursor++;
						lst_count++;
					end else begin
						for (i = lst_count; i > lst_cursor + 1; i--)
							lst_mem[i] = lst_mem[i - 1];
						lst_mem[lst_cursor + 1] = val;
						lst_count++;
					end
				end
				CMD_READ_POS: begin
					if (idx >= lst_count)
						r.status = ST_BAD_INDEX;
					else
						r.read_value = lst_mem[idx];
				end
				CMD_WRITE_POS: begin
					if (idx >= lst_count)
						r.status = ST_BAD_INDEX;
					else
						lst_mem[idx] = val;
				end
				default: ;
			endcase
		end
		if (lst_count > lst_peak)
			lst_peak = lst_count;
		r.element_count = lst_count[COUNT_W-1:0];
		r.cursor_position = lst_cursor[CURSOR_W-1:0];
		return r;
	endfunction

	// offer one command beat; called at a rising edge, returns at the edge that took it
	task automatic send_cmd(input logic [CMD_W-1:0] op, input logic [VALUE_W-1:0] val,
			input logic [POS_W-1:0] idx);
		logic [IN_TDATA_W-1:0] beat;
		beat = '0;
		beat[CMD_LSB +: CMD_W] = op;
		beat[VALUE_LSB +: VALUE_W] = val;
		beat[POS_LSB +: POS_W] = idx;
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= beat;
		do @(posedge clk); while (!s_axis_tready);
		pending_results.push_back(next_list_result(op, val, idx));
		cmds_sent++;
	endtask

	// result side backpressure
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
	end

	// compare every taken result beat against the oldest expectation
	always @(posedge clk) begin : result_check
		list_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				$error("result beat with no command outstanding");
				err_cnt++;
			end else begin
				want = pending_results.pop_front();
				if (m_axis_tdata[0 +: VALUE_W] !== want.read_value) begin
					$error("read_value: expected %0d, got %0d", $signed(want.read_value),
						$signed(m_axis_tdata[0 +: VALUE_W]));
					err_cnt++;
				end
				if (m_axis_tdata[MOVED_LSB] !== want.moved) begin
					$error("moved: expected %0d, got %0d", want.moved,
						m_axis_tdata[MOVED_LSB]);
					err_cnt++;
				end
				if (m_axis_tdata[STATUS_LSB +: 2] !== want.status) begin
					$error("status: expected %0d, got %0d", want.status,
						m_axis_tdata[STATUS_LSB +: 2]);
					err_cnt++;
				end
				if (m_axis_tdata[COUNT_LSB +: COUNT_W] !== want.element_count) begin
					$error("element_count: expected %0d, got %0d", want.element_count,
						m_axis_tdata[COUNT_LSB +: COUNT_W]);
					err_cnt++;
				end
				if (m_axis_tdata[CURSOR_LSB +: CURSOR_W] !== want.cursor_position) begin
					$error("cursor_position: expected %0d, got %0d", want.cursor_position,
						m_axis_tdata[CURSOR_LSB +: CURSOR_W]);
					err_cnt++;
				end
			end
		end
	end

	// every command but the inserts on an empty list, bad indexes and unknown codes
	task automatic test_empty_list();
		send_cmd(CMD_READ_CUR, 32'h0, 8'd0);
		send_cmd(CMD_WRITE_CUR, 32'h1234_5678, 8'd0);
		send_cmd(CMD_PREV, 32'h0, 8'd0);
		send_cmd(CMD_NEXT, 32'h0, 8'd0);
		send_cmd(CMD_FIRST, 32'h0, 8'd0);
		send_cmd(CMD_LAST, 32'h0, 8'd0);
		send_cmd(CMD_DELETE, 32'h0, 8'd0);
		send_cmd(CMD_READ_POS, 32'h0, 8'd0);
		send_cmd(CMD_WRITE_POS, 32'hffff_ffff, 8'd255);
		send_cmd(4'd11, 32'hffff_ffff, 8'd255);
		send_cmd(4'd15, 32'h0, 8'd0);
	endtask

	// insert into empty, before and after, moves stopping at both ends
	task automatic test_insert_and_move();
		send_cmd(CMD_INS_AFTER, 32'h8000_0000, 8'd0);
		send_cmd(CMD_INS_BEFORE, 32'h7fff_ffff, 8'd0);
		send_cmd(CMD_INS_AFTER, 32'hffff_ffff, 8'd0);
		send_cmd(CMD_PREV, 32'h0, 8'd0);
		send_cmd(CMD_PREV, 32'h0, 8'd0);
		send_cmd(CMD_LAST, 32'h0, 8'd0);
		send_cmd(CMD_NEXT, 32'h0, 8'd0);
		send_cmd(CMD_READ_CUR, 32'h0, 8'd0);
		send_cmd(CMD_WRITE_CUR, 32'h0, 8'd0);
		send_cmd(CMD_READ_POS, 32'h0, 8'd255);
		send_cmd(CMD_READ_POS, 32'h0, 8'd2);
		send_cmd(CMD_WRITE_POS, 32'h5a5a_a5a5, 8'd1);
	endtask

	// delete at the head closes the gap, delete at the tail steps back
	task automatic test_delete();
		send_cmd(CMD_FIRST, 32'h0, 8'd0);
		send_cmd(CMD_DELETE, 32'h0, 8'd0);
		send_cmd(CMD_LAST, 32'h0, 8'd0);
		send_cmd(CMD_DELETE, 32'h0, 8'd0);
		send_cmd(CMD_READ_POS, 32'h0, 8'd0);
	endtask

	// fill to capacity cheaply (insert before the tail), poke the full list,
	// then run the longest shifts at its head
	task automatic test_fill_to_full();
		send_cmd(CMD_LAST, 32'h0, 8'd0);
		while (lst_count < DEPTH_DEF)
			send_cmd(CMD_INS_BEFORE, $urandom, POS_W'($urandom_range(255)));
		send_cmd(CMD_INS_BEFORE, $urandom, 8'd0);
		send_cmd(CMD_INS_AFTER, $urandom, 8'd0);
		send_cmd(CMD_NEXT, 32'h0, 8'd0);
		send_cmd(CMD_READ_POS, 32'h0, 8'd255);
		send_cmd(CMD_WRITE_POS, 32'h8000_0000, 8'd255);
		send_cmd(CMD_READ_POS, 32'h0, 8'd255);
		// the longest shifts: delete and insert at the head of a full list
		send_cmd(CMD_FIRST, 32'h0, 8'd0);
		send_cmd(CMD_DELETE, 32'h0, 8'd0);
		send_cmd(CMD_INS_BEFORE, 32'h7fff_ffff, 8'd0);
		send_cmd(CMD_READ_POS, 32'h0, 8'd0);
		send_cmd(CMD_LAST, 32'h0, 8'd0);
	endtask

	// random command mix, inserts turn into deletes once the list grows long
	task automatic test_random_mix(input int n_cmds);
		int k;
		int pick;
		logic [CMD_W-1:0] op;
		logic [VALUE_W-1:0] val;
		logic [POS_W-1:0] idx;
		for (k = 0; k < n_cmds; k++) begin
			pick = $urandom_range(99);
			if (pick < 4)
				op = CMD_W'($urandom_range(15, 11));
			else if (pick < 26)
				op = (lst_count > 28) ? CMD_DELETE :
					($urandom_range(1) ? CMD_INS_BEFORE : CMD_INS_AFTER);
			else if (pick < 38)
				op = CMD_DELETE;
			else if (pick < 47)
				op = CMD_READ_CUR;
			else if (pick < 54)
				op = CMD_WRITE_CUR;
			else if (pick < 63)
				op = CMD_PREV;
			else if (pick < 72)
				op = CMD_NEXT;
			else if (pick < 76)
				op = CMD_FIRST;
			else if (pick < 80)
				op = CMD_LAST;
			else if (pick < 90)
				op = CMD_READ_POS;
			else
				op = CMD_WRITE_POS;
			case ($urandom_range(9))
				0: val = 32'h8000_0000;
				1: val = 32'h7fff_ffff;
				2: val = $urandom_range(1) ? 32'h0 : 32'hffff_ffff;
				default: val = $urandom;
			endcase
			// mostly near the valid range, including one past the end
			if ($urandom_range(3) != 0)
				idx = POS_W'($urandom_range(lst_count));
			else
				idx = POS_W'($urandom_range(255));
			send_cmd(op, val, idx);
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		src_idle_pct = 30;
		snk_idle_pct = 67;
		test_empty_list();
		test_insert_and_move();
		test_delete();
		test_random_mix(90);

		src_idle_pct = 67;
		snk_idle_pct = 30;
		test_fill_to_full();
		test_random_mix(90);

		src_idle_pct = 0;
		snk_idle_pct = 0;
		test_random_mix(90);

		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		// room for a stray late beat after a full-depth shift
		repeat (DEPTH_DEF + 20) @(posedge clk);

		$display("sent %0d commands, checked %0d result beats, list peaked at %0d of %0d",
			cmds_sent, results_seen, lst_peak, DEPTH_DEF);
		$display("covered empty, full and bad index cases, end stops and three idle mixes");
		if (err_cnt == 0) begin
			$display("** cursor_array_list_engine_core: PASSED **");
		end else begin
			$display("** cursor_array_list_engine_core: FAILED **");
		end
		$finish;
	end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/cale_pkg.sv
hw/rtl/cale_ctrl.sv
hw/rtl/cale_datapath.sv
hw/rtl/cursor_array_list_engine_core.sv
test/tb.sv
